@@ rtl/fdc_pkg.sv @@
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and the byte-wide crc update for the frame deframer.
// ----------------------------------------------------------------------------
package fdc_pkg;

   // crc-16 with 0xffff preset, polynomial 0x1021, msb first, no final xor
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   // configuration register indexes
   localparam logic [1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd2;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [3:0] {
      PH_SYNC1   = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_TYPE    = 4'd2,
      PH_EP      = 4'd3,
      PH_SEQ_LO  = 4'd4,
      PH_SEQ_HI  = 4'd5,
      PH_LEN_LO  = 4'd6,
      PH_LEN_HI  = 4'd7,
      PH_PAYLOAD = 4'd8,
      PH_CRC_LO  = 4'd9,
      PH_CRC_HI  = 4'd10
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  frame_type;
      logic [7:0]  endpoint;
      logic [15:0] sequence_res;
      logic [15:0] frame_length;
      logic        crc_ok;
      logic        frame_end;
   } result_type;

   // one byte through the crc, bit by bit
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/fdc_parser.sv @@
// ----------------------------------------------------------------------------
// fdc_parser
// Configuration registers, frame state machine, header capture and running
// crc. Produces at most one result for each accepted byte.
// ----------------------------------------------------------------------------
module fdc_parser
   import fdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        accept,
   input  logic [7:0]  rx_byte,
   output logic        res_valid,
   output result_type  res_data
);

   logic [7:0]  sync_first_ff;
   logic [7:0]  sync_second_ff;
   logic [15:0] max_payload_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [7:0]  held_endpoint_ff, held_endpoint_in;
   logic [15:0] held_sequence_ff, held_sequence_in;
   logic [15:0] held_length_ff, held_length_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  trailer_low_ff, trailer_low_in;

   logic [15:0] crc_next;
   logic [15:0] length_full;
   logic [15:0] seen_next;

   assign crc_next    = crc_byte(running_crc_ff, rx_byte);
   assign length_full = {rx_byte, held_length_ff[7:0]};
   assign seen_next   = bytes_seen_ff + 16'd1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= 8'd0;
         sync_second_ff <= 8'd0;
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[7:0];
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD: max_payload_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == sync_second_ff) begin
               phase_in = PH_TYPE;
            end else if (rx_byte != sync_first_ff) begin
               phase_in = PH_SYNC1;
            end
         end
         PH_TYPE:   phase_in = PH_EP;
         PH_EP:     phase_in = PH_SEQ_LO;
         PH_SEQ_LO: phase_in = PH_SEQ_HI;
         PH_SEQ_HI: phase_in = PH_LEN_LO;
         PH_LEN_LO: phase_in = PH_LEN_HI;
         PH_LEN_HI: begin
            if (length_full > max_payload_ff) begin
               phase_in = PH_SYNC1;
            end else if (length_full == 16'd0) begin
               phase_in = PH_CRC_LO;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (seen_next == held_length_ff) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: phase_in = PH_CRC_HI;
         PH_CRC_HI: phase_in = PH_SYNC1;
         default: begin
            // hunt for the first sync byte
            phase_in = (rx_byte == sync_first_ff) ? PH_SYNC2 : PH_SYNC1;
         end
      endcase
   end

   // header capture, crc and result
   always_comb begin
      held_type_in     = held_type_ff;
      held_endpoint_in = held_endpoint_ff;
      held_sequence_in = held_sequence_ff;
      held_length_in   = held_length_ff;
      bytes_seen_in    = bytes_seen_ff;
      running_crc_in   = running_crc_ff;
      trailer_low_in   = trailer_low_ff;
      res_valid        = 1'b0;
      res_data.kind         = KIND_PAYLOAD;
      res_data.data_byte    = 8'd0;
      res_data.frame_type   = held_type_ff;
      res_data.endpoint     = held_endpoint_ff;
      res_data.sequence_res = held_sequence_ff;
      res_data.frame_length = held_length_ff;
      res_data.crc_ok       = 1'b0;
      res_data.frame_end    = 1'b0;
      unique case (phase_ff)
         PH_SYNC2: begin
            if (rx_byte == sync_second_ff) begin
               running_crc_in = CRC_INIT;
            end
         end
         PH_TYPE: begin
            held_type_in   = rx_byte;
            running_crc_in = crc_next;
         end
         PH_EP: begin
            held_endpoint_in = rx_byte;
            running_crc_in   = crc_next;
         end
         PH_SEQ_LO: begin
            held_sequence_in = {8'd0, rx_byte};
            running_crc_in   = crc_next;
         end
         PH_SEQ_HI: begin
            held_sequence_in = {rx_byte, held_sequence_ff[7:0]};
            running_crc_in   = crc_next;
         end
         PH_LEN_LO: begin
            held_length_in = {8'd0, rx_byte};
            running_crc_in = crc_next;
         end
         PH_LEN_HI: begin
            held_length_in = length_full;
            running_crc_in = crc_next;
            if (length_full <= max_payload_ff) begin
               bytes_seen_in = 16'd0;
            end
         end
         PH_PAYLOAD: begin
            running_crc_in     = crc_next;
            bytes_seen_in      = seen_next;
            res_valid          = accept;
            res_data.data_byte = rx_byte;
         end
         PH_CRC_LO: begin
            trailer_low_in = rx_byte;
         end
         PH_CRC_HI: begin
            res_valid          = accept;
            res_data.kind      = KIND_VERDICT;
            res_data.crc_ok    = ({rx_byte, trailer_low_ff} == running_crc_ff);
            res_data.frame_end = 1'b1;
         end
         default: ;
      endcase
   end

   // state registers, advanced on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SYNC1;
         held_type_ff     <= 8'd0;
         held_endpoint_ff <= 8'd0;
         held_sequence_ff <= 16'd0;
         held_length_ff   <= 16'd0;
         bytes_seen_ff    <= 16'd0;
         running_crc_ff   <= CRC_INIT;
         trailer_low_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         held_type_ff     <= held_type_in;
         held_endpoint_ff <= held_endpoint_in;
         held_sequence_ff <= held_sequence_in;
         held_length_ff   <= held_length_in;
         bytes_seen_ff    <= bytes_seen_in;
         running_crc_ff   <= running_crc_in;
         trailer_low_ff   <= trailer_low_in;
      end
   end

   // payload count never reaches the header length while streaming
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> bytes_seen_ff < held_length_ff)
      else $error("payload count out of range");

   // results only come from payload or trailer bytes
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> accept && (phase_ff == PH_PAYLOAD || phase_ff == PH_CRC_HI))
      else $error("result outside payload or trailer");

   // trailer closes the frame and the hunt restarts
   assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_CRC_HI |=> phase_ff == PH_SYNC1)
      else $error("frame not closed after trailer");

   // an oversized length never enters the payload phase
   assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_LEN_HI && length_full > max_payload_ff |=> phase_ff == PH_SYNC1)
      else $error("oversized frame not dropped");

endmodule

@@ rtl/fdc_out_stage.sv @@
// ----------------------------------------------------------------------------
// fdc_out_stage
// Result register with one skid entry, so the input keeps flowing while a
// result waits to be taken, until the skid entry fills and stalls the input.
// ----------------------------------------------------------------------------
module fdc_out_stage
   import fdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_data,
   output logic       in_stall,
   output logic       out_valid,
   output result_type out_data,
   input  logic       out_stall
);

   logic       out_valid_ff;
   result_type out_data_ff;
   logic       skid_valid_ff;
   result_type skid_data_ff;
   logic       out_free;

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_free  = !out_valid_ff || !out_stall;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || in_valid;
         skid_valid_ff <= 1'b0;
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (!out_free && !skid_valid_ff) begin
         skid_data_ff <= in_data;
      end
   end

   // skid entry only fills behind a held result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full with empty output");

   // a held result with a full skid entry keeps both
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_stall |=> skid_valid_ff && out_valid_ff)
      else $error("result lost under stall");

   // a taken result with a full skid entry moves the skid entry forward
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_stall |=> out_valid_ff && !skid_valid_ff
         && out_data_ff == $past(skid_data_ff))
      else $error("skid entry not forwarded");

endmodule

@@ rtl/frame_deframer_crc16.sv @@
// ----------------------------------------------------------------------------
// frame_deframer_crc16
// Sync hunt, header parse, payload streaming and crc-16 trailer check.
// ----------------------------------------------------------------------------
// a result is registered, in the output or skid register, before rsp_valid
// one byte per cycle unless req_stall; header, crc and phase update per byte
// req_stall rises only when the result register and its skid entry are full
// reset (synchronous): hunt for first sync, crc preset 0xffff, sync bytes 0,
// max payload 1024, no result pending
module frame_deframer_crc16
   import fdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_frame_type,
   output logic [7:0]  rsp_endpoint,
   output logic [15:0] rsp_sequence_res,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_crc_ok,
   output logic        rsp_frame_end
);

   logic       accept;
   logic       res_valid;
   result_type res_data;
   result_type rsp_data;

   assign accept = req_valid && !req_stall;

   // frame parser
   fdc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .res_valid    (res_valid),
      .res_data     (res_data)
   );

   // result register with skid entry
   fdc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_data_byte    = rsp_data.data_byte;
   assign rsp_frame_type   = rsp_data.frame_type;
   assign rsp_endpoint     = rsp_data.endpoint;
   assign rsp_sequence_res = rsp_data.sequence_res;
   assign rsp_frame_length = rsp_data.frame_length;
   assign rsp_crc_ok       = rsp_data.crc_ok;
   assign rsp_frame_end    = rsp_data.frame_end;

endmodule
